// ----- rtl/lmb_pkg.sv -----
// lmb_pkg: shared constants and types of the level meter ballistics core
// coefficients are unsigned Q0.16, phase is unsigned Q3.12
// no dependencies
package lmb_pkg;

	localparam int LEVEL_BITS_DEF = 16;
	localparam int NUM_CH         = 4;
	localparam int COEF_BITS      = 16;
	localparam int HOLD_BITS      = 8;
	localparam int PHASE_BITS     = 15;

	localparam logic [COEF_BITS-1:0] REL_OLD    = 16'd57672;
	localparam logic [COEF_BITS-1:0] REL_NEW    = 16'd7864;
	localparam logic [COEF_BITS-1:0] PEAK_DECAY = 16'd60948;
	localparam logic [COEF_BITS-1:0] IN_OLD     = 16'd55706;
	localparam logic [COEF_BITS-1:0] IN_NEW     = 16'd9830;

	localparam logic [PHASE_BITS-1:0] PHASE_STEP   = 15'd410;
	localparam logic [PHASE_BITS-1:0] PHASE_TWO_PI = 15'd25736;

	localparam logic [HOLD_BITS-1:0] HOLD_RESET = 8'd30;
	localparam logic [HOLD_BITS-1:0] HOLD_MAX   = 8'd255;

	typedef struct packed {
		logic changed;
		logic active;
	} lane_stat_t;

endpackage

// ----- rtl/lmb_lane.sv -----
// lmb_lane: one channel of the meter, shown level ballistics and peak hold
// state is updated on each input transfer, status is derived from the registers
// depends on lmb_pkg
module lmb_lane import lmb_pkg::*; #(
	parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic [LEVEL_BITS-1:0] level,
	input  logic [HOLD_BITS-1:0]  hold_ticks,
	output logic [LEVEL_BITS-1:0] shown,
	output logic [LEVEL_BITS-1:0] peak,
	output lane_stat_t            stat
);

	localparam int PW = LEVEL_BITS + COEF_BITS;
	localparam logic [LEVEL_BITS-1:0] CHG_THR = LEVEL_BITS'(((1 << LEVEL_BITS) + 500) / 1000);
	localparam logic [LEVEL_BITS-1:0] ACT_THR = LEVEL_BITS'(((1 << LEVEL_BITS) + 50) / 100);

	logic [LEVEL_BITS-1:0] shown_q, peak_q, shown_prev_q, peak_prev_q;
	logic [HOLD_BITS-1:0]  hold_q;
	logic [PW-1:0]         mix, decay;
	logic [LEVEL_BITS-1:0] shown_n, peak_n;
	logic [HOLD_BITS-1:0]  hold_inc, hold_n;
	logic [LEVEL_BITS-1:0] shown_diff, peak_diff;

	assign mix   = PW'(shown_q) * PW'(REL_OLD) + PW'(level) * PW'(REL_NEW);
	assign decay = PW'(peak_q) * PW'(PEAK_DECAY);

	always_comb begin
		shown_n  = (level > shown_q) ? level : mix[PW-1:COEF_BITS];
		hold_inc = (hold_q == HOLD_MAX) ? HOLD_MAX : hold_q + HOLD_BITS'(1);
		if (level >= peak_q) begin
			peak_n = level;
			hold_n = '0;
		end else begin
			hold_n = hold_inc;
			peak_n = (hold_inc > hold_ticks) ? decay[PW-1:COEF_BITS] : peak_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_q <= '0;
			peak_q  <= '0;
			hold_q  <= '0;
		end else if (load) begin
			shown_q <= shown_n;
			peak_q  <= peak_n;
			hold_q  <= hold_n;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			shown_prev_q <= shown_q;
			peak_prev_q  <= peak_q;
		end
	end

	assign shown_diff = (shown_q > shown_prev_q) ? shown_q - shown_prev_q
	                                             : shown_prev_q - shown_q;
	assign peak_diff  = (peak_q > peak_prev_q) ? peak_q - peak_prev_q
	                                           : peak_prev_q - peak_q;

	assign stat.changed = (shown_diff > CHG_THR) || (peak_diff > CHG_THR);
	assign stat.active  = shown_q > ACT_THR;
	assign shown        = shown_q;
	assign peak         = peak_q;

endmodule

// ----- rtl/lmb_smooth.sv -----
// lmb_smooth: first-order smoother of the overall input level
// updated on each input transfer, change flag from the registers
// depends on lmb_pkg
module lmb_smooth import lmb_pkg::*; #(
	parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic [LEVEL_BITS-1:0] level,
	output logic [LEVEL_BITS-1:0] shown,
	output logic                  changed
);

	localparam int PW = LEVEL_BITS + COEF_BITS;
	localparam logic [LEVEL_BITS-1:0] CHG_THR = LEVEL_BITS'(((1 << LEVEL_BITS) + 500) / 1000);

	logic [LEVEL_BITS-1:0] shown_q, shown_prev_q, diff;
	logic [PW-1:0]         mix;

	assign mix = PW'(shown_q) * PW'(IN_OLD) + PW'(level) * PW'(IN_NEW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_q <= '0;
		end else if (load) begin
			shown_q <= mix[PW-1:COEF_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			shown_prev_q <= shown_q;
		end
	end

	assign diff    = (shown_q > shown_prev_q) ? shown_q - shown_prev_q : shown_prev_q - shown_q;
	assign changed = diff > CHG_THR;
	assign shown   = shown_q;

endmodule

// ----- rtl/lmb_merge.sv -----
// lmb_merge: combines lane status and the input change flag into activity and redraw,
// advances the phase while active and holds the output register of one result
// depends on lmb_pkg
module lmb_merge import lmb_pkg::*; #(
	parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic [LEVEL_BITS-1:0] shown_ch [NUM_CH],
	input  logic [LEVEL_BITS-1:0] peak_ch [NUM_CH],
	input  lane_stat_t            stat [NUM_CH],
	input  logic [LEVEL_BITS-1:0] shown_lin,
	input  logic                  in_changed,
	output logic [LEVEL_BITS-1:0] shown_o [NUM_CH],
	output logic [LEVEL_BITS-1:0] peak_o [NUM_CH],
	output logic [LEVEL_BITS-1:0] shown_in_o,
	output logic [PHASE_BITS-1:0] phase_o,
	output logic                  redraw_o
);

	logic                  active, changed;
	logic [PHASE_BITS-1:0] phase_q, phase_add, phase_n;

	always_comb begin
		active  = 1'b0;
		changed = in_changed;
		for (int i = 0; i < NUM_CH; i++) begin
			active  = active | stat[i].active;
			changed = changed | stat[i].changed;
		end
	end

	always_comb begin
		phase_add = phase_q + PHASE_STEP;
		if (!active) begin
			phase_n = phase_q;
		end else if (phase_add > PHASE_TWO_PI) begin
			phase_n = phase_add - PHASE_TWO_PI;
		end else begin
			phase_n = phase_add;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (load) begin
			phase_q <= phase_n;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			shown_o    <= shown_ch;
			peak_o     <= peak_ch;
			shown_in_o <= shown_lin;
			phase_o    <= phase_n;
			redraw_o   <= changed | active;
		end
	end

endmodule

// ----- rtl/level_meter_ballistics_peak_hold_core.sv -----
// level_meter_ballistics_peak_hold_core: top level of the peak hold level meter
// four channel lanes, an input smoother and a merge stage with the output register
// depends on lmb_pkg, lmb_lane, lmb_smooth, lmb_merge
//
//   channel  handshake            payload
//   in       in_valid / in_ready  level_vocals .. level_other, level_in
//   out      out_valid / out_ready shown_*, peak_*, shown_in, anim_phase, redraw
//   cfg      cfg_we               cfg_wdata (hold_ticks)
//
// one tick per clock sustained while the output is not stalled; a result passes from its
// transfer through the lane state registers into the merge stage's output register
// arst_n clears the lane and smoother levels, peaks, hold counters and the phase; hold_ticks to 30
// a stalled output holds its result; one further tick is taken into the lanes
// and waits there, so in_ready falls only when both stages are full
module level_meter_ballistics_peak_hold_core import lmb_pkg::*; #(
	parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [HOLD_BITS-1:0]  cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [LEVEL_BITS-1:0] level_vocals,
	input  logic [LEVEL_BITS-1:0] level_drums,
	input  logic [LEVEL_BITS-1:0] level_bass,
	input  logic [LEVEL_BITS-1:0] level_other,
	input  logic [LEVEL_BITS-1:0] level_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [LEVEL_BITS-1:0] shown_vocals,
	output logic [LEVEL_BITS-1:0] shown_drums,
	output logic [LEVEL_BITS-1:0] shown_bass,
	output logic [LEVEL_BITS-1:0] shown_other,
	output logic [LEVEL_BITS-1:0] peak_vocals,
	output logic [LEVEL_BITS-1:0] peak_drums,
	output logic [LEVEL_BITS-1:0] peak_bass,
	output logic [LEVEL_BITS-1:0] peak_other,
	output logic [LEVEL_BITS-1:0] shown_in,
	output logic [PHASE_BITS-1:0] anim_phase,
	output logic                  redraw
);

	logic [HOLD_BITS-1:0]  hold_ticks_q;
	logic                  valid_s1, out_valid_q;
	logic                  advance, accept, load_out;
	logic [LEVEL_BITS-1:0] level_ch [NUM_CH];
	logic [LEVEL_BITS-1:0] shown_ch [NUM_CH];
	logic [LEVEL_BITS-1:0] peak_ch [NUM_CH];
	lane_stat_t            stat [NUM_CH];
	logic [LEVEL_BITS-1:0] shown_lin;
	logic                  in_changed;
	logic [LEVEL_BITS-1:0] shown_o [NUM_CH];
	logic [LEVEL_BITS-1:0] peak_o [NUM_CH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q <= HOLD_RESET;
		end else if (cfg_we) begin
			hold_ticks_q <= cfg_wdata;
		end
	end

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;
	assign load_out = advance && valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	assign level_ch[0] = level_vocals;
	assign level_ch[1] = level_drums;
	assign level_ch[2] = level_bass;
	assign level_ch[3] = level_other;

	for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
		lmb_lane #(.LEVEL_BITS(LEVEL_BITS)) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.load      (accept),
			.level     (level_ch[g]),
			.hold_ticks(hold_ticks_q),
			.shown     (shown_ch[g]),
			.peak      (peak_ch[g]),
			.stat      (stat[g])
		);
	end

	lmb_smooth #(.LEVEL_BITS(LEVEL_BITS)) u_smooth (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.level  (level_in),
		.shown  (shown_lin),
		.changed(in_changed)
	);

	lmb_merge #(.LEVEL_BITS(LEVEL_BITS)) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load_out),
		.shown_ch  (shown_ch),
		.peak_ch   (peak_ch),
		.stat      (stat),
		.shown_lin (shown_lin),
		.in_changed(in_changed),
		.shown_o   (shown_o),
		.peak_o    (peak_o),
		.shown_in_o(shown_in),
		.phase_o   (anim_phase),
		.redraw_o  (redraw)
	);

	assign out_valid    = out_valid_q;
	assign shown_vocals = shown_o[0];
	assign shown_drums  = shown_o[1];
	assign shown_bass   = shown_o[2];
	assign shown_other  = shown_o[3];
	assign peak_vocals  = peak_o[0];
	assign peak_drums   = peak_o[1];
	assign peak_bass    = peak_o[2];
	assign peak_other   = peak_o[3];

endmodule

// ----- rtl/lmb_checker.sv -----
// lmb_checker: port-level assertions for the level meter core
// bound to level_meter_ballistics_peak_hold_core, depends on lmb_pkg
module lmb_checker import lmb_pkg::*; #(
	parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_we,
	input logic [HOLD_BITS-1:0]  cfg_wdata,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic [LEVEL_BITS-1:0] level_vocals,
	input logic [LEVEL_BITS-1:0] level_drums,
	input logic [LEVEL_BITS-1:0] level_bass,
	input logic [LEVEL_BITS-1:0] level_other,
	input logic [LEVEL_BITS-1:0] level_in,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [LEVEL_BITS-1:0] shown_vocals,
	input logic [LEVEL_BITS-1:0] shown_drums,
	input logic [LEVEL_BITS-1:0] shown_bass,
	input logic [LEVEL_BITS-1:0] shown_other,
	input logic [LEVEL_BITS-1:0] peak_vocals,
	input logic [LEVEL_BITS-1:0] peak_drums,
	input logic [LEVEL_BITS-1:0] peak_bass,
	input logic [LEVEL_BITS-1:0] peak_other,
	input logic [LEVEL_BITS-1:0] shown_in,
	input logic [PHASE_BITS-1:0] anim_phase,
	input logic                  redraw
);

	localparam logic [LEVEL_BITS-1:0] ACT_THR = LEVEL_BITS'(((1 << LEVEL_BITS) + 50) / 100);

	logic any_active;

	assign any_active = (shown_vocals > ACT_THR) || (shown_drums > ACT_THR) ||
	                    (shown_bass > ACT_THR) || (shown_other > ACT_THR);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(anim_phase) && $stable(redraw) &&
		$stable(shown_vocals) && $stable(peak_vocals) && $stable(shown_in))
		else $error("stalled result changed");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> anim_phase <= PHASE_TWO_PI)
		else $error("phase beyond two pi");

	a_active_redraw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && any_active |-> redraw)
		else $error("active meter without redraw");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input blocked without output stall");

endmodule

bind level_meter_ballistics_peak_hold_core lmb_checker #(.LEVEL_BITS(LEVEL_BITS)) u_lmb_checker (.*);
